### hdl/dts_pkg.sv
// ============================================================================
// dts_pkg - shared types and constants for the dependency sorter
// Port field widths, FSM state type, error codes and register indexes.
// ============================================================================
package dts_pkg;

    // FSM states of the sorter
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_COUNT,
        ST_PUSH,
        ST_POP,
        ST_FETCH,
        ST_RELAX,
        ST_EMIT_RD,
        ST_EMIT_LD,
        ST_ERR
    } state_t;

    // result error codes
    typedef enum logic [1:0] {
        ERR_NONE    = 2'd0,
        ERR_SELF    = 2'd1,
        ERR_MISSING = 2'd2,
        ERR_CYCLE   = 2'd3
    } err_t;

    // command carried on s_tuser
    localparam logic CMD_EDGE = 1'b0;
    localparam logic CMD_SORT = 1'b1;

    // field widths
    localparam int NODE_W    = 5;
    localparam int DEP_W     = 6;
    localparam int CNT_W     = 6;
    localparam int ERR_W     = 2;
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 8;

    // register port
    localparam int APB_AW  = 3;
    localparam int APB_DW  = 32;
    localparam int REG_LSB = 2;
    localparam logic REG_NODE_COUNT = 1'b0;

    localparam logic [CNT_W-1:0] NODE_COUNT_RST = 6'd32;

endpackage

### hdl/dependency_topological_sort.sv
// ============================================================================
// dependency_topological_sort - Kahn sort of a loaded dependency graph
// Edges are loaded one per transfer; a sort command emits the node order.
// ============================================================================
// Usage:
//   s_* carries commands. s_tuser = 0 loads the edge "s_tdata[4:0] depends on
//   s_tdata[10:5]"; s_tuser = 1 starts a sort. Edge loads are taken one per
//   cycle (read-modify-write of a matrix row with forwarding between
//   neighbors). s_tready stays low from a sort command until its last result
//   is in the output register.
//   m_* carries results: m_tdata[4:0] node index, m_tlast on the final one,
//   m_tuser error code. A clean sort gives one result per active node; a recorded
//   self or missing dependency, or a cycle, gives a single result.
//   A sort runs an in-degree sweep over the matrix memory, then per node a
//   pop, row fetch, relax and push (one stack write per cycle), and then
//   reads the order back from the list memory. A recorded load error skips
//   the sweep and goes straight to the error result. A stalled receiver
//   holds the output register and the sorter waits. The user writes
//   node_count (APB offset 0) while idle only; the block does not enforce
//   it. Reset: synchronous on aresetn low; the graph is empty,
//   node_count = 32. The graph and recorded error are cleared after every sort.
// ============================================================================
module dependency_topological_sort #(
    parameter int MAX_NODES = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // APB register port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [dts_pkg::APB_AW-1:0]    paddr,
    input  logic [dts_pkg::APB_DW-1:0]    pwdata,
    output logic [dts_pkg::APB_DW-1:0]    prdata,
    output logic                          pready,
    // command stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [dts_pkg::S_TDATA_W-1:0] s_tdata,   // node[4:0], depends_on[10:5]
    input  logic                          s_tuser,   // cmd
    // result stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [dts_pkg::M_TDATA_W-1:0] m_tdata,   // order_node[4:0]
    output logic                          m_tlast,
    output logic [dts_pkg::ERR_W-1:0]     m_tuser    // error[1:0]
);
    import dts_pkg::*;

    localparam int AW  = $clog2(MAX_NODES);       // node index
    localparam int NW  = $clog2(MAX_NODES + 1);   // node count
    localparam int PW  = $clog2(MAX_NODES);       // in-degree, at most MAX_NODES-1
    localparam int LW  = AW + 1;                  // list memory: stack half, order half
    localparam int LDEPTH = 2 * (2 ** AW);
    localparam int CW1 = CNT_W + 1;

    // ------------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------------
    state_t                 state_reg, state_next;
    logic [CNT_W-1:0]       node_count_reg;
    err_t                   first_error_reg, first_error_next;
    err_t                   err_code_reg, err_code_next;
    logic [MAX_NODES-1:0]   row_valid_reg, row_valid_next;

    // edge write stage and last-write forwarding
    logic                   e_valid_reg, e_valid_next;
    logic [AW-1:0]          e_addr_reg, e_addr_next;
    logic [AW-1:0]          e_bit_reg, e_bit_next;
    logic                   lw_valid_reg;
    logic [AW-1:0]          lw_addr_reg;
    logic [MAX_NODES-1:0]   lw_data_reg;

    logic [PW-1:0]          pend_reg [MAX_NODES];
    logic [PW-1:0]          pend_next [MAX_NODES];
    logic [MAX_NODES-1:0]   free_reg, free_next;
    logic [NW-1:0]          sp_reg, sp_next;
    logic [NW-1:0]          count_reg, count_next;
    logic [NW-1:0]          i_reg, i_next;
    logic                   cnt_v_reg, cnt_v_next;
    logic [AW-1:0]          cnt_row_reg, cnt_row_next;
    logic [AW-1:0]          top_reg, top_next;

    logic                   m_valid_reg, m_valid_next;
    logic [NODE_W-1:0]      m_node_reg, m_node_next;
    logic                   m_last_reg, m_last_next;
    err_t                   m_err_reg, m_err_next;

    // memories
    logic [MAX_NODES-1:0]   mat_mem [MAX_NODES];
    logic [MAX_NODES-1:0]   mat_rd_reg;
    logic [AW-1:0]          list_mem [LDEPTH];
    logic [AW-1:0]          list_rd_reg;

    // ------------------------------------------------------------------------
    // combinational signals
    // ------------------------------------------------------------------------
    logic [CW1-1:0]         nc_ext, n_wide;
    logic [NW-1:0]          n_act;
    logic [MAX_NODES-1:0]   col_mask;
    logic [NODE_W-1:0]      in_node;
    logic [DEP_W-1:0]       in_dep;
    logic                   accept, sort_acc, edge_acc;
    logic                   node_in, dep_in, self_dep, edge_ok;
    logic                   out_free, free_any, stack_empty, emit_last, cnt_done;
    logic [AW-1:0]          ff_idx;
    logic [MAX_NODES-1:0]   ff_onehot;
    logic [MAX_NODES-1:0]   pend_zero, pend_one;
    logic [MAX_NODES-1:0]   cnt_row, relax_row;
    logic [MAX_NODES-1:0]   mat_base, mat_wdata;
    logic [NW-1:0]          sp_dec;

    // control
    logic                   mat_re;
    logic [AW-1:0]          mat_raddr;
    logic                   list_we, list_re;
    logic [LW-1:0]          list_waddr, list_raddr;
    logic [AW-1:0]          list_wdata;
    logic                   out_load, graph_clear;

    // ------------------------------------------------------------------------
    // register port
    // ------------------------------------------------------------------------
    logic cfg_we;
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready
                    && (paddr[REG_LSB] == REG_NODE_COUNT);
    assign prdata = (paddr[REG_LSB] == REG_NODE_COUNT) ? APB_DW'(node_count_reg) : '0;

    // active node count: 0 acts as 1, above MAX_NODES clamps
    assign nc_ext = {1'b0, node_count_reg};
    always_comb begin
        if (node_count_reg == '0) begin
            n_wide = CW1'(1);
        end else if (nc_ext > CW1'(MAX_NODES)) begin
            n_wide = CW1'(MAX_NODES);
        end else begin
            n_wide = nc_ext;
        end
        n_act = NW'(n_wide);
    end

    always_comb begin
        for (int m = 0; m < MAX_NODES; m++) begin
            col_mask[m]  = (m < int'(n_act));
            pend_zero[m] = (pend_reg[m] == '0);
            pend_one[m]  = (pend_reg[m] == PW'(1));
        end
    end

    // ------------------------------------------------------------------------
    // input decode
    // ------------------------------------------------------------------------
    assign in_node  = s_tdata[NODE_W-1:0];
    assign in_dep   = s_tdata[NODE_W+DEP_W-1:NODE_W];
    assign accept   = s_tvalid && s_tready;
    assign sort_acc = accept && (s_tuser == CMD_SORT);
    assign edge_acc = accept && (s_tuser == CMD_EDGE);
    assign node_in  = int'(in_node) < int'(n_act);
    assign dep_in   = int'(in_dep) < int'(n_act);
    assign self_dep = ({1'b0, in_node} == in_dep);
    assign edge_ok  = edge_acc && node_in && !self_dep && dep_in;

    // ------------------------------------------------------------------------
    // shared conditions
    // ------------------------------------------------------------------------
    assign out_free    = !m_valid_reg || m_tready;
    assign free_any    = (free_reg != '0);
    assign stack_empty = (sp_reg == '0);
    assign sp_dec      = sp_reg - NW'(1);
    assign emit_last   = ((i_reg + NW'(1)) == n_act);
    assign cnt_done    = (i_reg == n_act) && !cnt_v_reg;

    // lowest pending free node is pushed first
    always_comb begin
        ff_idx = '0;
        for (int m = MAX_NODES - 1; m >= 0; m--) begin
            if (free_reg[m]) begin
                ff_idx = AW'(m);
            end
        end
    end
    assign ff_onehot = {{(MAX_NODES-1){1'b0}}, 1'b1} << ff_idx;

    // matrix rows as seen by the sweep and the relax step; a row never
    // written since the last clear reads as zero
    assign cnt_row   = mat_rd_reg & col_mask & {MAX_NODES{row_valid_reg[cnt_row_reg]}};
    assign relax_row = mat_rd_reg & col_mask & {MAX_NODES{row_valid_reg[top_reg]}};

    // edge write: forward the previous cycle's write to the same row
    always_comb begin
        if (lw_valid_reg && (lw_addr_reg == e_addr_reg)) begin
            mat_base = lw_data_reg;
        end else if (row_valid_reg[e_addr_reg]) begin
            mat_base = mat_rd_reg;
        end else begin
            mat_base = '0;
        end
        mat_wdata = mat_base | ({{(MAX_NODES-1){1'b0}}, 1'b1} << e_bit_reg);
    end

    // ------------------------------------------------------------------------
    // next state
    // ------------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (sort_acc) begin
                    state_next = (first_error_reg != ERR_NONE) ? ST_ERR : ST_COUNT;
                end
            end
            ST_COUNT: begin
                if (cnt_done) begin
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH: begin
                if (!free_any) begin
                    state_next = ST_POP;
                end
            end
            ST_POP: begin
                priority if (!stack_empty) begin
                    state_next = ST_FETCH;
                end else if (count_reg == n_act) begin
                    state_next = ST_EMIT_RD;
                end else begin
                    state_next = ST_ERR;
                end
            end
            ST_FETCH:   state_next = ST_RELAX;
            ST_RELAX:   state_next = ST_PUSH;
            ST_EMIT_RD: state_next = ST_EMIT_LD;
            ST_EMIT_LD: begin
                if (out_free) begin
                    state_next = emit_last ? ST_IDLE : ST_EMIT_RD;
                end
            end
            ST_ERR: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------------
    // FSM outputs: memory ports and result load
    // ------------------------------------------------------------------------
    always_comb begin
        s_tready    = 1'b0;
        mat_re      = 1'b0;
        mat_raddr   = in_dep[AW-1:0];
        list_we     = 1'b0;
        list_waddr  = {1'b0, sp_reg[AW-1:0]};
        list_wdata  = ff_idx;
        list_re     = 1'b0;
        list_raddr  = {1'b0, sp_dec[AW-1:0]};
        out_load    = 1'b0;
        graph_clear = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                mat_re   = edge_ok;
            end
            ST_COUNT: begin
                mat_re    = (i_reg < n_act);
                mat_raddr = i_reg[AW-1:0];
            end
            ST_PUSH: begin
                list_we = free_any;
            end
            ST_POP: begin
                list_re = !stack_empty;
            end
            ST_FETCH: begin
                mat_re     = 1'b1;
                mat_raddr  = list_rd_reg;
                list_we    = 1'b1;
                list_waddr = {1'b1, count_reg[AW-1:0]};
                list_wdata = list_rd_reg;
            end
            ST_RELAX: begin
            end
            ST_EMIT_RD: begin
                list_re    = 1'b1;
                list_raddr = {1'b1, i_reg[AW-1:0]};
            end
            ST_EMIT_LD: begin
                out_load    = out_free;
                graph_clear = out_free && emit_last;
            end
            ST_ERR: begin
                out_load    = out_free;
                graph_clear = out_free;
            end
            default: begin
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // datapath next values
    // ------------------------------------------------------------------------
    always_comb begin
        first_error_next = first_error_reg;
        err_code_next    = err_code_reg;
        row_valid_next   = row_valid_reg;
        e_valid_next     = edge_ok;
        e_addr_next      = in_dep[AW-1:0];
        e_bit_next       = AW'(in_node);
        free_next        = free_reg;
        sp_next          = sp_reg;
        count_next       = count_reg;
        i_next           = i_reg;
        cnt_v_next       = 1'b0;
        cnt_row_next     = i_reg[AW-1:0];
        top_next         = top_reg;
        m_valid_next     = m_valid_reg && !m_tready;
        m_node_next      = m_node_reg;
        m_last_next      = m_last_reg;
        m_err_next       = m_err_reg;
        for (int m = 0; m < MAX_NODES; m++) begin
            pend_next[m] = pend_reg[m];
        end

        if (e_valid_reg) begin
            row_valid_next[e_addr_reg] = 1'b1;
        end

        // first load error wins
        if (edge_acc && node_in && (first_error_reg == ERR_NONE)) begin
            if (self_dep) begin
                first_error_next = ERR_SELF;
            end else if (!dep_in) begin
                first_error_next = ERR_MISSING;
            end
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (sort_acc) begin
                    err_code_next = first_error_reg;
                    sp_next       = '0;
                    count_next    = '0;
                    i_next        = '0;
                    for (int m = 0; m < MAX_NODES; m++) begin
                        pend_next[m] = '0;
                    end
                end
            end
            ST_COUNT: begin
                cnt_v_next = mat_re;
                if (mat_re) begin
                    i_next = i_reg + NW'(1);
                end
                if (cnt_v_reg) begin
                    for (int m = 0; m < MAX_NODES; m++) begin
                        pend_next[m] = pend_reg[m] + PW'(cnt_row[m]);
                    end
                end
                if (cnt_done) begin
                    free_next = pend_zero & col_mask;
                end
            end
            ST_PUSH: begin
                if (free_any) begin
                    sp_next   = sp_reg + NW'(1);
                    free_next = free_reg & ~ff_onehot;
                end
            end
            ST_POP: begin
                if (!stack_empty) begin
                    sp_next = sp_dec;
                end else begin
                    i_next        = '0;
                    err_code_next = ERR_CYCLE;
                end
            end
            ST_FETCH: begin
                top_next   = list_rd_reg;
                count_next = count_reg + NW'(1);
            end
            ST_RELAX: begin
                for (int m = 0; m < MAX_NODES; m++) begin
                    pend_next[m] = pend_reg[m] - PW'(relax_row[m]);
                end
                free_next = relax_row & pend_one;
            end
            ST_EMIT_RD: begin
            end
            ST_EMIT_LD: begin
                if (out_load) begin
                    m_node_next = NODE_W'(list_rd_reg);
                    m_last_next = emit_last;
                    m_err_next  = ERR_NONE;
                    i_next      = i_reg + NW'(1);
                end
            end
            ST_ERR: begin
                if (out_load) begin
                    m_node_next = '0;
                    m_last_next = 1'b1;
                    m_err_next  = err_code_reg;
                end
            end
            default: begin
            end
        endcase

        if (out_load) begin
            m_valid_next = 1'b1;
        end
        if (graph_clear) begin
            row_valid_next   = '0;
            first_error_next = ERR_NONE;
        end
    end

    // ------------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            node_count_reg  <= NODE_COUNT_RST;
            first_error_reg <= ERR_NONE;
            row_valid_reg   <= '0;
            e_valid_reg     <= 1'b0;
            lw_valid_reg    <= 1'b0;
            free_reg        <= '0;
            sp_reg          <= '0;
            count_reg       <= '0;
            i_reg           <= '0;
            cnt_v_reg       <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            if (cfg_we) begin
                node_count_reg <= pwdata[CNT_W-1:0];
            end
            first_error_reg <= first_error_next;
            row_valid_reg   <= row_valid_next;
            e_valid_reg     <= e_valid_next;
            lw_valid_reg    <= e_valid_reg;
            free_reg        <= free_next;
            sp_reg          <= sp_next;
            count_reg       <= count_next;
            i_reg           <= i_next;
            cnt_v_reg       <= cnt_v_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        err_code_reg <= err_code_next;
        e_addr_reg   <= e_addr_next;
        e_bit_reg    <= e_bit_next;
        lw_addr_reg  <= e_addr_reg;
        lw_data_reg  <= mat_wdata;
        cnt_row_reg  <= cnt_row_next;
        top_reg      <= top_next;
        m_node_reg   <= m_node_next;
        m_last_reg   <= m_last_next;
        m_err_reg    <= m_err_next;
        for (int m = 0; m < MAX_NODES; m++) begin
            pend_reg[m] <= pend_next[m];
        end
    end

    // dependents matrix: row d, bit n set when n depends on d
    always_ff @(posedge aclk) begin
        if (e_valid_reg) begin
            mat_mem[e_addr_reg] <= mat_wdata;
        end
        if (mat_re) begin
            mat_rd_reg <= mat_mem[mat_raddr];
        end
    end

    // ready stack (lower half) and emitted order (upper half)
    always_ff @(posedge aclk) begin
        if (list_we) begin
            list_mem[list_waddr] <= list_wdata;
        end
        if (list_re) begin
            list_rd_reg <= list_mem[list_raddr];
        end
    end

    // ------------------------------------------------------------------------
    // outputs
    // ------------------------------------------------------------------------
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_TDATA_W-NODE_W){1'b0}}, m_node_reg};
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_err_reg;

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
`ifndef ASSERT_OFF
    // each node is pushed at most once, so the stack never outgrows the graph
    a_sp_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> (sp_reg <= n_act))
        else $error("ready stack deeper than node count");

    // a node is popped at most once
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> (count_reg <= n_act))
        else $error("more nodes popped than exist");

    // an edge is relaxed only while its target still waits on it
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RELAX) |-> ((relax_row & pend_zero) == '0))
        else $error("in-degree underflow");

    // a final clean result always closes a complete order
    a_full_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT_LD && out_load && emit_last) |-> (count_reg == n_act))
        else $error("order emitted with nodes missing");
`endif

endmodule
